// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file drt_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DRT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define DRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/drt_pkg.sv -----
// shared types and constants of the dirty rectangle tracker
// no dependencies
`timescale 1ns / 1ps

package drt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int IN_W        = 16;
    localparam int COORD_W     = 15;
    localparam int SLOT_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int OUTCOME_W   = 2;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 72;

    // result kinds carried on tuser
    localparam logic [OUTCOME_W-1:0] OUT_REJECT = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_APPEND = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_MERGE  = 2'd2;

    // configuration register indexes
    localparam logic CFG_SCREEN_W = 1'b0;
    localparam logic CFG_SCREEN_H = 1'b1;

    localparam logic [COORD_W-1:0] SCREEN_W_RST = 15'd320;
    localparam logic [COORD_W-1:0] SCREEN_H_RST = 15'd240;

    // left in the lowest bits
    typedef struct packed {
        logic [COORD_W-1:0] height;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
    } t_rect;

    localparam int RECT_W = $bits(t_rect);

    typedef struct packed {
        logic  ok;
        t_rect rect;
    } t_clip;

endpackage

// ----- hw/rtl/drt_ram.sv -----
// single-port-write, single-port-read synchronous ram, registered read data
// no dependencies
`timescale 1ns / 1ps

module drt_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/drt_clip.sv -----
// clips an incoming rectangle to the screen and registers the result
// depends on drt_pkg
`timescale 1ns / 1ps

module drt_clip (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [drt_pkg::IN_W-1:0]      i_left,
    input  logic [drt_pkg::IN_W-1:0]      i_top,
    input  logic [drt_pkg::IN_W-1:0]      i_width,
    input  logic [drt_pkg::IN_W-1:0]      i_height,
    input  logic [drt_pkg::COORD_W-1:0]   i_screen_w,
    input  logic [drt_pkg::COORD_W-1:0]   i_screen_h,
    output drt_pkg::t_clip                o_clip
);

    import drt_pkg::*;

    logic signed [17:0] x_ext, y_ext, w_ext, h_ext;
    logic signed [17:0] x_end, y_end, sw_ext, sh_ext;
    logic signed [17:0] x_lo, y_lo, x_hi, y_hi, w_clip, h_clip;
    logic               size_ok;
    t_clip              n_clip;
    t_clip              r_clip;

    always_comb begin
        x_ext  = 18'(signed'(i_left));
        y_ext  = 18'(signed'(i_top));
        w_ext  = 18'(signed'(i_width));
        h_ext  = 18'(signed'(i_height));
        sw_ext = signed'({3'b000, i_screen_w});
        sh_ext = signed'({3'b000, i_screen_h});
        // right edge is unchanged by left clipping
        x_end  = x_ext + w_ext;
        y_end  = y_ext + h_ext;
        x_lo   = i_left[IN_W-1] ? 18'sd0 : x_ext;
        y_lo   = i_top[IN_W-1]  ? 18'sd0 : y_ext;
        x_hi   = (x_end > sw_ext) ? sw_ext : x_end;
        y_hi   = (y_end > sh_ext) ? sh_ext : y_end;
        w_clip = x_hi - x_lo;
        h_clip = y_hi - y_lo;
        size_ok = (w_ext > 18'sd0) && (h_ext > 18'sd0);

        n_clip.ok          = size_ok && (w_clip > 18'sd0) && (h_clip > 18'sd0);
        n_clip.rect.left   = x_lo[COORD_W-1:0];
        n_clip.rect.top    = y_lo[COORD_W-1:0];
        n_clip.rect.width  = w_clip[COORD_W-1:0];
        n_clip.rect.height = h_clip[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_clip <= n_clip;
        end
    end

    assign o_clip = r_clip;

endmodule

// ----- hw/rtl/drt_merge.sv -----
// bounding box of two on-screen rectangles
// depends on drt_pkg
`timescale 1ns / 1ps

module drt_merge (
    input  drt_pkg::t_rect i_a,
    input  drt_pkg::t_rect i_b,
    output drt_pkg::t_rect o_box
);

    import drt_pkg::*;

    logic [COORD_W:0] a_right, b_right, x1, y1, a_bot, b_bot;
    logic [COORD_W-1:0] x0, y0;

    always_comb begin
        a_right = {1'b0, i_a.left} + {1'b0, i_a.width};
        b_right = {1'b0, i_b.left} + {1'b0, i_b.width};
        a_bot   = {1'b0, i_a.top} + {1'b0, i_a.height};
        b_bot   = {1'b0, i_b.top} + {1'b0, i_b.height};
        x0 = (i_b.left < i_a.left) ? i_b.left : i_a.left;
        y0 = (i_b.top < i_a.top) ? i_b.top : i_a.top;
        x1 = (b_right > a_right) ? b_right : a_right;
        y1 = (b_bot > a_bot) ? b_bot : a_bot;
        o_box.left   = x0;
        o_box.top    = y0;
        o_box.width  = COORD_W'(x1 - {1'b0, x0});
        o_box.height = COORD_W'(y1 - {1'b0, y0});
    end

endmodule

// ----- hw/rtl/dirty_rect_tracker.sv -----
// top level of the dirty rectangle tracker
// depends on drt_pkg, drt_clip, drt_merge, drt_ram
`timescale 1ns / 1ps

// usage
// - input beats on the s channel carry one rectangle each (left, top, width,
//   height, signed 16 bit). each beat yields exactly one result beat on the
//   m channel: tuser holds the outcome (reject, append, merge), tdata holds
//   the slot written, the stored rectangle and the entry count afterwards
// - screen size is set through the write port (index 0 width, 1 height);
//   write it only while no beat is in flight
// - one beat at a time: the clip is registered on acceptance, the next cycle
//   decides and, for append or reject, loads the output register once it is
//   free. a merge reads entry 0 from the table ram, whose read data is
//   registered, and writes the bounding box back from the read state
// - the result is registered; a new beat is taken only once the state
//   machine is back in idle, a merge adding the ram read as an extra step
// - a stalled result sits in the output register while the next beat is
//   accepted and clipped; the result then waits until the register frees
// - reset clears the count, the state machine and the output valid and
//   loads the screen size 320 x 240; the table ram is not cleared, since an
//   entry is only read back after it was written

module dirty_rect_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // s channel: left[15:0], top[31:16], width[47:32], height[63:48]
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [drt_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // m channel: slot[3:0], left[18:4], top[33:19], width[48:34],
    // height[63:49], count[68:64], zero fill[71:69]
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [drt_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // outcome[1:0]
    output logic [drt_pkg::OUTCOME_W-1:0]      o_m_tuser,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_addr,
    input  logic [drt_pkg::COORD_W-1:0]        i_cfg_wdata
);

    import drt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [COORD_W-1:0]    r_screen_w, r_screen_h;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [OUTCOME_W-1:0]  r_out_user, n_out_user;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                  s_accept, out_free, full;
    t_clip                 clip;
    t_rect                 entry0, merged, out_rect;
    logic [SLOT_W-1:0]     out_slot;

    // table ram ports
    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr;
    logic [RECT_W-1:0]     ram_wdata, ram_rdata;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign full       = (r_count >= CNT_W'(TABLE_DEPTH));
    assign entry0     = t_rect'(ram_rdata);

    drt_clip u_clip (
        .i_clk      (i_clk),
        .i_load     (s_accept),
        .i_left     (i_s_tdata[15:0]),
        .i_top      (i_s_tdata[31:16]),
        .i_width    (i_s_tdata[47:32]),
        .i_height   (i_s_tdata[63:48]),
        .i_screen_w (r_screen_w),
        .i_screen_h (r_screen_h),
        .o_clip     (clip)
    );

    drt_merge u_merge (
        .i_a   (entry0),
        .i_b   (clip.rect),
        .o_box (merged)
    );

    // reads and writes of the table never fall in the same cycle: a write
    // ends an item, and the next read comes only from a later beat after idle
    drt_ram #(
        .WIDTH (RECT_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr ('0),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_user  = r_out_user;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_count[IDX_W-1:0];
        ram_wdata   = clip.rect;
        out_rect    = '0;
        out_slot    = '0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (clip.ok && full) begin
                    // fetch slot zero for the bounding box
                    ram_re  = 1'b1;
                    n_state = S_READ;
                end else if (out_free) begin
                    if (clip.ok) begin
                        ram_we     = 1'b1;
                        n_count    = r_count + 1'b1;
                        out_rect   = clip.rect;
                        out_slot   = SLOT_W'(r_count);
                        n_out_user = OUT_APPEND;
                    end else begin
                        n_out_user = OUT_REJECT;
                    end
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, COUNT_W'(n_count), out_rect, out_slot};
                    n_state     = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    ram_we      = 1'b1;
                    ram_waddr   = '0;
                    ram_wdata   = merged;
                    n_count     = CNT_W'(1);
                    out_rect    = merged;
                    n_out_user  = OUT_MERGE;
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, COUNT_W'(n_count), out_rect, out_slot};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_screen_w  <= SCREEN_W_RST;
            r_screen_h  <= SCREEN_H_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SCREEN_W: r_screen_w <= i_cfg_wdata;
                    CFG_SCREEN_H: r_screen_h <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out_user <= n_out_user;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_user;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- hw/rtl/drt_checker.sv -----
// port-level checks of the dirty rectangle tracker, bound to the top level
// depends on drt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module drt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [drt_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [drt_pkg::OUTCOME_W-1:0]  o_m_tuser
);

    import drt_pkg::*;

    // stalled result holds
    `DRT_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // a rejected beat reports slot and rectangle as zero
    `DRT_ASSERT_IMPLY(a_reject_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == OUT_REJECT), o_m_tdata[63:0] == 64'd0)

    // a merge always lands in slot zero and leaves one entry
    `DRT_ASSERT_IMPLY(a_merge_slot, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == OUT_MERGE), (o_m_tdata[3:0] == 4'd0) && (o_m_tdata[68:64] == 5'd1))

    // an append fills the slot just below the new count
    `DRT_ASSERT_IMPLY(a_append_slot, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == OUT_APPEND), o_m_tdata[68:64] == ({1'b0, o_m_tdata[3:0]} + 5'd1))

endmodule

bind dirty_rect_tracker drt_checker u_drt_checker (.*);
